/* hw/rtl/kmsf_pkg.sv */
// ----------------------------------------------------------------------------
// kmsf_pkg
// Shared constants and controller/datapath signal groups for the
// minimum spanning forest builder.
// ----------------------------------------------------------------------------
package kmsf_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAX_EDGES_DEF    = 256;
	localparam int WEIGHT_BITS_DEF  = 32;
	localparam int VW               = 6;   // vertex field width
	localparam int VCW              = 7;   // vertex count register width
	localparam int TOTAL_EXTRA      = 6;   // growth bits of the weight sum
	localparam logic [VCW-1:0] VCOUNT_RST = 7'd64;

	// edge memory read address source
	typedef enum logic [1:0] {
		EA_I    = 2'd0,
		EA_J    = 2'd1,
		EA_SORT = 2'd2
	} ea_sel_t;

	typedef struct packed {
		logic    add;        // store the input edge (or drop it)
		logic    start;      // begin a build
		logic    i_clr;
		logic    i_inc;
		logic    j_clr;
		logic    j_inc;
		ea_sel_t ea_sel;
		logic    wi_ld;      // capture pivot weight
		logic    rank_cmp;   // compare and count
		logic    so_wr;      // write sorted position
		logic    e_ld;       // capture current edge
		logic    v_ld_from;
		logic    v_ld_to;
		logic    v_ld_p;
		logic    ra_ld;
		logic    rb_ld;
		logic    par_wr;     // union and accumulate
		logic    pend_push;  // move held edge to output
		logic    pend_ld;    // hold current edge
		logic    fin_ld;     // load final word
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic i_last;
		logic j_last;
		logic is_root;
		logic roots_eq;
		logic pend_v;
		logic out_free;
	} status_t;

endpackage

/* hw/rtl/kmsf_if.sv */
// ----------------------------------------------------------------------------
// kmsf_in_if / kmsf_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface kmsf_in_if #(parameter int WEIGHT_BITS = 32);
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic [5:0]                    edge_from;
	logic [5:0]                    edge_to;
	logic signed [WEIGHT_BITS-1:0] edge_weight;
	modport source (output valid, mode, edge_from, edge_to, edge_weight, input ready);
	modport sink (input valid, mode, edge_from, edge_to, edge_weight, output ready);
endinterface

interface kmsf_out_if #(parameter int WEIGHT_BITS = 32);
	logic                            valid;
	logic                            ready;
	logic                            edge_valid;
	logic [5:0]                      tree_from;
	logic [5:0]                      tree_to;
	logic signed [WEIGHT_BITS-1:0]   tree_weight;
	logic signed [WEIGHT_BITS+5:0]   total_weight;
	logic                            edges_dropped;
	logic                            last;
	modport source (output valid, edge_valid, tree_from, tree_to, tree_weight,
		total_weight, edges_dropped, last, input ready);
	modport sink (input valid, edge_valid, tree_from, tree_to, tree_weight,
		total_weight, edges_dropped, last, output ready);
endinterface

/* hw/rtl/kmsf_ctrl.sv */
// ----------------------------------------------------------------------------
// kmsf_ctrl
// Sequencer: edge intake, rank sort, union-find walk and result release.
// ----------------------------------------------------------------------------
module kmsf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_mode,
	output logic              in_ready,
	input  kmsf_pkg::status_t sts,
	output kmsf_pkg::cmd_t    cmd
);
	import kmsf_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001,
		S_RI_RD  = 16'h0002,
		S_RI_CAP = 16'h0004,
		S_RJ_RD  = 16'h0008,
		S_RJ_CMP = 16'h0010,
		S_R_WR   = 16'h0020,
		S_U_RDS  = 16'h0040,
		S_U_RDE  = 16'h0080,
		S_U_CAP  = 16'h0100,
		S_FA_RD  = 16'h0200,
		S_FA_CK  = 16'h0400,
		S_FB_RD  = 16'h0800,
		S_FB_CK  = 16'h1000,
		S_U_DEC  = 16'h2000,
		S_U_PUSH = 16'h4000,
		S_FIN    = 16'h8000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.ea_sel = EA_I;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (!in_mode) begin
						cmd.add = 1'b1;
					end else begin
						cmd.start = 1'b1;
						cmd.i_clr = 1'b1;
						state_d = sts.cnt_zero ? S_FIN : S_RI_RD;
					end
				end
			end
			S_RI_RD: begin
				cmd.ea_sel = EA_I;
				state_d = S_RI_CAP;
			end
			S_RI_CAP: begin
				cmd.wi_ld = 1'b1;
				cmd.j_clr = 1'b1;
				state_d = S_RJ_RD;
			end
			S_RJ_RD: begin
				cmd.ea_sel = EA_J;
				state_d = S_RJ_CMP;
			end
			S_RJ_CMP: begin
				cmd.rank_cmp = 1'b1;
				if (sts.j_last) begin
					state_d = S_R_WR;
				end else begin
					cmd.j_inc = 1'b1;
					state_d = S_RJ_RD;
				end
			end
			S_R_WR: begin
				cmd.so_wr = 1'b1;
				if (sts.i_last) begin
					cmd.i_clr = 1'b1;
					state_d = S_U_RDS;
				end else begin
					cmd.i_inc = 1'b1;
					state_d = S_RI_RD;
				end
			end
			S_U_RDS: begin
				state_d = S_U_RDE;
			end
			S_U_RDE: begin
				cmd.ea_sel = EA_SORT;
				state_d = S_U_CAP;
			end
			S_U_CAP: begin
				cmd.e_ld = 1'b1;
				cmd.v_ld_from = 1'b1;
				state_d = S_FA_RD;
			end
			S_FA_RD: begin
				state_d = S_FA_CK;
			end
			S_FA_CK: begin
				if (sts.is_root) begin
					cmd.ra_ld = 1'b1;
					cmd.v_ld_to = 1'b1;
					state_d = S_FB_RD;
				end else begin
					cmd.v_ld_p = 1'b1;
					state_d = S_FA_RD;
				end
			end
			S_FB_RD: begin
				state_d = S_FB_CK;
			end
			S_FB_CK: begin
				if (sts.is_root) begin
					cmd.rb_ld = 1'b1;
					state_d = S_U_DEC;
				end else begin
					cmd.v_ld_p = 1'b1;
					state_d = S_FB_RD;
				end
			end
			S_U_DEC: begin
				if (!sts.roots_eq) begin
					cmd.par_wr = 1'b1;
					state_d = S_U_PUSH;
				end else if (sts.i_last) begin
					state_d = S_FIN;
				end else begin
					cmd.i_inc = 1'b1;
					state_d = S_U_RDS;
				end
			end
			S_U_PUSH: begin
				if (!sts.pend_v || sts.out_free) begin
					cmd.pend_push = sts.pend_v;
					cmd.pend_ld = 1'b1;
					if (sts.i_last) begin
						state_d = S_FIN;
					end else begin
						cmd.i_inc = 1'b1;
						state_d = S_U_RDS;
					end
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.fin_ld = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef NO_ASSERTIONS
	// a build only starts from idle
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> $past(state_q) == state_q || state_q == S_IDLE)
		else $error("build started outside idle");
	// the final word is always followed by idle
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin_ld |=> state_q == S_IDLE)
		else $error("no return to idle after final word");
	// a held edge is never overwritten before it is pushed
	a_pend_safe: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pend_ld && sts.pend_v) |-> cmd.pend_push)
		else $error("held edge lost");
`endif
endmodule

/* hw/rtl/kmsf_datapath.sv */
// ----------------------------------------------------------------------------
// kmsf_datapath
// Edge store, sort order memory, parent table, counters and output register.
// ----------------------------------------------------------------------------
module kmsf_datapath #(
	parameter int MAX_VERTICES = kmsf_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = kmsf_pkg::MAX_EDGES_DEF,
	parameter int WEIGHT_BITS  = kmsf_pkg::WEIGHT_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  kmsf_pkg::cmd_t                         cmd,
	output kmsf_pkg::status_t                      sts,
	input  logic [kmsf_pkg::VW-1:0]                in_from,
	input  logic [kmsf_pkg::VW-1:0]                in_to,
	input  logic signed [WEIGHT_BITS-1:0]          in_weight,
	input  logic                                   cfg_we,
	input  logic [kmsf_pkg::VCW-1:0]               cfg_wdata,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   out_edge_valid,
	output logic [kmsf_pkg::VW-1:0]                out_from,
	output logic [kmsf_pkg::VW-1:0]                out_to,
	output logic signed [WEIGHT_BITS-1:0]          out_weight,
	output logic signed [WEIGHT_BITS+kmsf_pkg::TOTAL_EXTRA-1:0] out_total,
	output logic                                   out_dropped,
	output logic                                   out_last
);
	import kmsf_pkg::*;

	localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CW = $clog2(MAX_EDGES + 1);
	localparam int PW = $clog2(MAX_VERTICES);
	localparam int TW = WEIGHT_BITS + TOTAL_EXTRA;
	localparam int EW = 2 * VW + WEIGHT_BITS;

	logic [VCW-1:0]                vcount_q;
	logic [CW-1:0]                 cnt_q;
	logic                          drop_q;
	logic [AW-1:0]                 i_q, j_q, rank_q;
	logic signed [WEIGHT_BITS-1:0] wi_q;
	logic [EW-1:0]                 emem [MAX_EDGES];
	logic [EW-1:0]                 edata_q;
	logic [AW-1:0]                 smem [MAX_EDGES];
	logic [AW-1:0]                 sdata_q;
	logic [VW-1:0]                 pmem [MAX_VERTICES];
	logic [VW-1:0]                 pdata_q;
	logic [MAX_VERTICES-1:0]       pvalid_q;
	logic                          pval_q;
	logic [VW-1:0]                 ef_q, et_q, v_q, ra_q, rb_q;
	logic signed [WEIGHT_BITS-1:0] ew_q;
	logic signed [TW-1:0]          sum_q;
	logic                          pend_v_q;
	logic [VW-1:0]                 pf_q, pt_q;
	logic signed [WEIGHT_BITS-1:0] pw_q;
	logic                          ov_q;

	logic [VCW-1:0]                nv;
	logic                          drop_now, add_ok;
	logic [AW-1:0]                 eaddr;
	logic signed [WEIGHT_BITS-1:0] ej_w;
	logic                          less;
	logic [VW-1:0]                 p_eff;

	// intake check
	assign nv = (vcount_q > VCW'(MAX_VERTICES)) ? VCW'(MAX_VERTICES) : vcount_q;
	assign drop_now = (cnt_q == CW'(MAX_EDGES)) || ({1'b0, in_from} >= nv)
		|| ({1'b0, in_to} >= nv);
	assign add_ok = cmd.add && !drop_now;

	// config, count and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_RST;
			cnt_q    <= '0;
			drop_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				vcount_q <= cfg_wdata;
			end
			if (add_ok) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.add && drop_now) begin
				drop_q <= 1'b1;
			end
		end
	end

	// edge store
	always_comb begin
		case (cmd.ea_sel)
			EA_I:    eaddr = i_q;
			EA_J:    eaddr = j_q;
			EA_SORT: eaddr = sdata_q;
			default: eaddr = i_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (add_ok) begin
			emem[cnt_q[AW-1:0]] <= {in_from, in_to, in_weight};
		end
		edata_q <= emem[eaddr];
	end

	// sort order memory
	always_ff @(posedge clk) begin
		if (cmd.so_wr) begin
			smem[rank_q] <= i_q;
		end
		sdata_q <= smem[i_q];
	end

	// rank counting: earlier equal weights come first
	assign ej_w = edata_q[WEIGHT_BITS-1:0];
	assign less = (ej_w < wi_q) || ((ej_w == wi_q) && (j_q < i_q));

	always_ff @(posedge clk) begin
		if (cmd.i_clr) begin
			i_q <= '0;
		end else if (cmd.i_inc) begin
			i_q <= i_q + AW'(1);
		end
		if (cmd.j_clr) begin
			j_q <= '0;
		end else if (cmd.j_inc) begin
			j_q <= j_q + AW'(1);
		end
		if (cmd.j_clr) begin
			rank_q <= '0;
		end else if (cmd.rank_cmp && less) begin
			rank_q <= rank_q + AW'(1);
		end
		if (cmd.wi_ld) begin
			wi_q <= edata_q[WEIGHT_BITS-1:0];
		end
	end

	// parent table; an entry not written since build start is its own root
	always_ff @(posedge clk) begin
		if (cmd.par_wr) begin
			pmem[ra_q[PW-1:0]] <= rb_q;
		end
		pdata_q <= pmem[v_q[PW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_q <= '0;
			pval_q   <= 1'b0;
		end else begin
			if (cmd.start) begin
				pvalid_q <= '0;
			end else if (cmd.par_wr) begin
				pvalid_q[ra_q[PW-1:0]] <= 1'b1;
			end
			pval_q <= pvalid_q[v_q[PW-1:0]];
		end
	end

	assign p_eff = pval_q ? pdata_q : v_q;

	// current edge and root walk
	always_ff @(posedge clk) begin
		if (cmd.e_ld) begin
			ef_q <= edata_q[EW-1 -: VW];
			et_q <= edata_q[WEIGHT_BITS +: VW];
			ew_q <= edata_q[WEIGHT_BITS-1:0];
		end
		if (cmd.v_ld_from) begin
			v_q <= edata_q[EW-1 -: VW];
		end else if (cmd.v_ld_to) begin
			v_q <= et_q;
		end else if (cmd.v_ld_p) begin
			v_q <= p_eff;
		end
		if (cmd.ra_ld) begin
			ra_q <= v_q;
		end
		if (cmd.rb_ld) begin
			rb_q <= v_q;
		end
		if (cmd.pend_ld) begin
			pf_q <= ef_q;
			pt_q <= et_q;
			pw_q <= ew_q;
		end
	end

	// running sum and held edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			pend_v_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				sum_q <= '0;
			end else if (cmd.par_wr) begin
				sum_q <= sum_q + TW'(ew_q);
			end
			if (cmd.start || cmd.fin_ld) begin
				pend_v_q <= 1'b0;
			end else if (cmd.pend_ld) begin
				pend_v_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.pend_push || cmd.fin_ld) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pend_push || cmd.fin_ld) begin
			out_edge_valid <= pend_v_q;
			out_from       <= pend_v_q ? pf_q : '0;
			out_to         <= pend_v_q ? pt_q : '0;
			out_weight     <= pend_v_q ? pw_q : '0;
			out_total      <= cmd.fin_ld ? sum_q : '0;
			out_dropped    <= drop_q;
			out_last       <= cmd.fin_ld;
		end
	end

	assign out_valid = ov_q;

	// status
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.i_last   = (CW'(i_q) == cnt_q - CW'(1));
	assign sts.j_last   = (CW'(j_q) == cnt_q - CW'(1));
	assign sts.is_root  = (p_eff == v_q);
	assign sts.roots_eq = (ra_q == rb_q);
	assign sts.pend_v   = pend_v_q;
	assign sts.out_free = !ov_q || out_ready;

`ifndef NO_ASSERTIONS
	// the edge count never passes the store size
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_EDGES))
		else $error("edge count overflow");
	// a sorted position lies inside the stored edges
	a_rank_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.so_wr |-> CW'(rank_q) < cnt_q)
		else $error("rank out of range");
	// a union only joins two different trees
	a_union: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.par_wr |-> ra_q != rb_q)
		else $error("union of a tree with itself");
	// the output register is never loaded over an untaken word
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pend_push || cmd.fin_ld) |-> (!ov_q || out_ready))
		else $error("output word overwritten");
`endif
endmodule

/* hw/rtl/kruskal_min_spanning_forest.sv */
// ----------------------------------------------------------------------------
// kruskal_min_spanning_forest
// Minimum spanning forest builder over a stored edge list.
// ----------------------------------------------------------------------------
// Usage: in_ch takes words; mode 0 stores an edge (one per cycle, back to
// back, no result), mode 1 builds the forest. An edge whose endpoint is at or
// above the vertex count, or that arrives with the store full, is dropped and
// sets the sticky edges_dropped flag. cfg_we/cfg_wdata write vertex_count.
// A build of n stored edges first ranks the edges by weight (one edge memory
// read per compare), then runs the union-find walk over the edges in sorted
// order, walking the root paths of both endpoints and adding a push step for
// an edge that joins two trees. Results leave on out_ch, one
// word per forest edge; the last word carries last and total_weight. An empty
// forest gives one word with edge_valid 0. A stalled out_ch holds the walk
// when a new forest edge is found while the output register and the held
// edge are both full; a stored edge word is never lost. in_ch is ready only
// between builds. Reset clears the edge count, drop flag and output, and sets
// vertex_count to 64; no clearing pass is needed.
// ----------------------------------------------------------------------------
module kruskal_min_spanning_forest #(
	parameter int MAX_VERTICES = kmsf_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = kmsf_pkg::MAX_EDGES_DEF,
	parameter int WEIGHT_BITS  = kmsf_pkg::WEIGHT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	kmsf_in_if.sink                     in_ch,
	kmsf_out_if.source                  out_ch,
	input  logic                        cfg_we,
	input  logic [kmsf_pkg::VCW-1:0]    cfg_wdata
);
	import kmsf_pkg::*;

	cmd_t    cmd;
	status_t sts;

	// sequencer
	kmsf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_mode  (in_ch.mode),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage and arithmetic
	kmsf_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_from        (in_ch.edge_from),
		.in_to          (in_ch.edge_to),
		.in_weight      (in_ch.edge_weight),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.out_edge_valid (out_ch.edge_valid),
		.out_from       (out_ch.tree_from),
		.out_to         (out_ch.tree_to),
		.out_weight     (out_ch.tree_weight),
		.out_total      (out_ch.total_weight),
		.out_dropped    (out_ch.edges_dropped),
		.out_last       (out_ch.last)
	);
endmodule
